[hdl/sje_pkg.sv]
package sje_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_JOG_STEP   = 3'd0;
    localparam logic [2:0] REG_ANGLE_LIM  = 3'd1;
    localparam logic [2:0] REG_FIRST_ID   = 3'd2;
    localparam logic [2:0] REG_SECOND_ID  = 3'd3;

    // Register and state reset values.
    localparam logic [8:0] JOG_STEP_RST   = 9'd5;
    localparam logic [8:0] ANGLE_LIM_RST  = 9'd300;
    localparam logic [7:0] FIRST_ID_RST   = 8'd1;
    localparam logic [7:0] SECOND_ID_RST  = 8'd2;
    localparam logic [8:0] ANGLE_RST      = 9'd170;

    // Largest angle in degrees.
    localparam logic [8:0] ANGLE_MAX      = 9'd300;

    // Jog command bytes.
    localparam logic [7:0] CMD_FIRST_DOWN  = 8'h31;
    localparam logic [7:0] CMD_FIRST_UP    = 8'h32;
    localparam logic [7:0] CMD_SECOND_DOWN = 8'h33;
    localparam logic [7:0] CMD_SECOND_UP   = 8'h34;

    // Opcode carried in tuser.
    localparam logic OP_JOG    = 1'b0;
    localparam logic OP_DIRECT = 1'b1;

    // Fixed packet bytes.
    localparam logic [7:0] PKT_HEADER  = 8'hFF;
    localparam logic [7:0] PKT_LENGTH  = 8'h05;
    localparam logic [7:0] PKT_WRITE   = 8'h03;
    localparam logic [7:0] PKT_GOAL    = 8'h1E;
    localparam logic [7:0] PKT_FIXED_SUM = PKT_LENGTH + PKT_WRITE + PKT_GOAL;

    // Byte positions inside one packet.
    localparam logic [3:0] IDX_HDR0  = 4'd0;
    localparam logic [3:0] IDX_HDR1  = 4'd1;
    localparam logic [3:0] IDX_ID    = 4'd2;
    localparam logic [3:0] IDX_LEN   = 4'd3;
    localparam logic [3:0] IDX_INSTR = 4'd4;
    localparam logic [3:0] IDX_ADDR  = 4'd5;
    localparam logic [3:0] IDX_POS_L = 4'd6;
    localparam logic [3:0] IDX_POS_H = 4'd7;
    localparam logic [3:0] IDX_CHK   = 4'd8;

    // Position scaling: floor(angle * 1023 / 300) is computed as
    // floor((angle * 1023 / 4) * RECIP_MUL / 2^RECIP_SHIFT), which is exact
    // for every quotient below 77000.
    localparam logic [17:0] RECIP_MUL  = 18'd223697;
    localparam int          RECIP_SHIFT = 24;

    typedef struct packed {
        logic [8:0] jog_step;
        logic [8:0] angle_limit;
        logic [7:0] first_id;
        logic [7:0] second_id;
    } cfg_t;

    // One pending packet: servo id and 10-bit goal position.
    typedef struct packed {
        logic [7:0] id;
        logic [9:0] pos;
    } pkt_req_t;

    // Queue status seen by the front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Select one byte of a packet.
    function automatic logic [7:0] pkt_byte(input logic [3:0] idx, input logic [7:0] id,
                                            input logic [9:0] pos, input logic [7:0] chk);
        logic [7:0] b;
        unique case (idx)
            IDX_HDR0:  b = PKT_HEADER;
            IDX_HDR1:  b = PKT_HEADER;
            IDX_ID:    b = id;
            IDX_LEN:   b = PKT_LENGTH;
            IDX_INSTR: b = PKT_WRITE;
            IDX_ADDR:  b = PKT_GOAL;
            IDX_POS_L: b = pos[7:0];
            IDX_POS_H: b = {6'b0, pos[9:8]};
            IDX_CHK:   b = chk;
            default:   b = chk;
        endcase
        return b;
    endfunction

endpackage

[hdl/servo_jog_packet_encoder.sv]
// The first packet byte follows an item transfer through the front pipeline, the queue,
// the back sequencer and its output register. Each packet is 9 byte transfers, sent back
// to back while m_tready holds; the front pipeline and queue absorb the next items.
// Reset is asynchronous: registers return to their defaults, both angles to 170,
// and the pipeline, queue and output stage are emptied.
module servo_jog_packet_encoder
    import sje_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // command_byte[7:0], target_id[15:8], target_angle[24:16]
    input  logic        s_tuser,  // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // packet_byte[7:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    cfg_t     cfg_reg, cfg_next;
    q_stat_t  q_stat;
    logic     q_push;
    logic     q_pop;
    pkt_req_t q_wr;
    pkt_req_t q_rd;

    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_JOG_STEP:  cfg_next.jog_step    = cfg_data;
                REG_ANGLE_LIM: cfg_next.angle_limit = cfg_data;
                REG_FIRST_ID:  cfg_next.first_id    = cfg_data[7:0];
                REG_SECOND_ID: cfg_next.second_id   = cfg_data[7:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.jog_step    <= JOG_STEP_RST;
            cfg_reg.angle_limit <= ANGLE_LIM_RST;
            cfg_reg.first_id    <= FIRST_ID_RST;
            cfg_reg.second_id   <= SECOND_ID_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sje_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_data   (q_wr)
    );

    sje_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr),
        .pop     (q_pop),
        .rd_data (q_rd),
        .stat    (q_stat)
    );

    sje_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .q_head   (q_rd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("packet queue overflow");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("packet queue underflow");

    // Input back-pressure only comes from a full queue.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_stat.full)
        else $error("input stalled without a full queue");

endmodule

[hdl/sje_queue.sv]
module sje_queue
    import sje_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  pkt_req_t wr_data,
    input  logic     pop,
    output pkt_req_t rd_data,
    output q_stat_t  stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pkt_req_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign rd_data    = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_FULL);
    assign stat.empty = (count_reg == '0);

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[hdl/sje_front.sv]
module sje_front
    import sje_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  cfg_t        cfg,
    input  q_stat_t     q_stat,
    output logic        q_push,
    output pkt_req_t    q_data
);

    logic [7:0] cmd;
    logic [7:0] tid;
    logic [8:0] tang;
    logic       accept;
    logic       enable;

    logic       cmd_hit;
    logic       sel_second;
    logic       step_up;
    logic [8:0] cur_angle;
    logic [8:0] limit;
    logic [9:0] up_sum;
    logic       jog_ok;
    logic [8:0] new_angle;
    logic [8:0] direct_angle;

    logic [8:0] first_angle_reg, first_angle_next;
    logic [8:0] second_angle_reg, second_angle_next;

    logic       a_valid_reg;
    logic [7:0] a_id_reg;
    logic [8:0] a_angle_reg;
    logic       b_valid_reg;
    logic [7:0] b_id_reg;
    logic [16:0] b_y_reg;
    logic       c_valid_reg;
    logic [7:0] c_id_reg;
    logic [9:0] c_pos_reg;

    logic [18:0] a_scaled;
    logic [34:0] b_prod;

    assign cmd  = s_tdata[7:0];
    assign tid  = s_tdata[15:8];
    assign tang = s_tdata[24:16];

    // The pipeline moves unless the last stage holds an entry the queue cannot take.
    assign enable   = !c_valid_reg || !q_stat.full;
    assign s_tready = enable;
    assign accept   = s_tvalid && s_tready;

    // Command decode.
    always_comb
    begin
        cmd_hit    = 1'b1;
        sel_second = 1'b0;
        step_up    = 1'b0;
        unique case (cmd)
            CMD_FIRST_DOWN:
            begin
                sel_second = 1'b0;
                step_up    = 1'b0;
            end
            CMD_FIRST_UP:
            begin
                sel_second = 1'b0;
                step_up    = 1'b1;
            end
            CMD_SECOND_DOWN:
            begin
                sel_second = 1'b1;
                step_up    = 1'b0;
            end
            CMD_SECOND_UP:
            begin
                sel_second = 1'b1;
                step_up    = 1'b1;
            end
            default:
            begin
                cmd_hit = 1'b0;
            end
        endcase
    end

    // Step range check, the new angle and the clamped direct angle.
    always_comb
    begin
        cur_angle    = sel_second ? second_angle_reg : first_angle_reg;
        limit        = (cfg.angle_limit > ANGLE_MAX) ? ANGLE_MAX : cfg.angle_limit;
        up_sum       = {1'b0, cur_angle} + {1'b0, cfg.jog_step};
        new_angle    = step_up ? up_sum[8:0] : (cur_angle - cfg.jog_step);
        jog_ok       = cmd_hit && (step_up ? (up_sum <= {1'b0, limit})
                                           : (cur_angle >= cfg.jog_step));
        direct_angle = (tang > ANGLE_MAX) ? ANGLE_MAX : tang;
    end

    // Stored angles change only on an accepted jog that stays in range.
    always_comb
    begin
        first_angle_next  = first_angle_reg;
        second_angle_next = second_angle_reg;
        if (accept && (s_tuser == OP_JOG) && jog_ok)
        begin
            if (sel_second)
            begin
                second_angle_next = new_angle;
            end
            else
            begin
                first_angle_next = new_angle;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_angle_reg  <= ANGLE_RST;
            second_angle_reg <= ANGLE_RST;
        end
        else
        begin
            first_angle_reg  <= first_angle_next;
            second_angle_reg <= second_angle_next;
        end
    end

    // Scaling: angle * 1023 / 4, then the reciprocal multiply by 1/75.
    assign a_scaled = {a_angle_reg, 10'b0} - {10'b0, a_angle_reg};
    assign b_prod   = {18'b0, b_y_reg} * {17'b0, RECIP_MUL};

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            a_valid_reg <= accept && ((s_tuser == OP_DIRECT) || jog_ok);
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            a_id_reg    <= (s_tuser == OP_DIRECT) ? tid
                         : (sel_second ? cfg.second_id : cfg.first_id);
            a_angle_reg <= (s_tuser == OP_DIRECT) ? direct_angle : new_angle;
            b_id_reg    <= a_id_reg;
            b_y_reg     <= a_scaled[18:2];
            c_id_reg    <= b_id_reg;
            c_pos_reg   <= b_prod[RECIP_SHIFT+9:RECIP_SHIFT];
        end
    end

    assign q_push      = c_valid_reg && enable;
    assign q_data.id   = c_id_reg;
    assign q_data.pos  = c_pos_reg;

endmodule

[hdl/sje_back.sv]
module sje_back
    import sje_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_stat_t    q_stat,
    input  pkt_req_t   q_head,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic       load;
    logic       at_end;

    logic       act_reg, act_next;
    logic [3:0] idx_reg, idx_next;
    logic [7:0] id_reg;
    logic [9:0] pos_reg;
    logic [7:0] chk_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic [7:0] head_sum;

    // The output register takes a new byte when empty or being drained.
    assign load   = !out_valid_reg || m_tready;
    assign at_end = (idx_reg == IDX_CHK);
    assign q_pop  = load && !q_stat.empty && (!act_reg || at_end);

    assign head_sum = q_head.id + PKT_FIXED_SUM + q_head.pos[7:0] + {6'b0, q_head.pos[9:8]};

    // Byte sequencer.
    always_comb
    begin
        act_next       = act_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = act_reg;
            if (act_reg)
            begin
                idx_next = idx_reg + 1'b1;
                if (at_end)
                begin
                    act_next = 1'b0;
                end
            end
            if (q_pop)
            begin
                act_next = 1'b1;
                idx_next = IDX_HDR0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            idx_reg       <= IDX_HDR0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            act_reg       <= act_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Packet fields and the output byte.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            id_reg  <= q_head.id;
            pos_reg <= q_head.pos;
            chk_reg <= ~head_sum;
        end
        if (load && act_reg)
        begin
            out_byte_reg <= pkt_byte(idx_reg, id_reg, pos_reg, chk_reg);
            out_last_reg <= at_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule
